@@ src/tmc_pkg.sv @@
// ============================================================================
// TCP MSS clamp parser package
// Shared result type, register indexes and protocol constants.
// ============================================================================
package tmc_pkg;

	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_MIN_MSS_IPV4 = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_MSS_IPV6 = 1'b1;

	localparam logic [15:0] MIN_MSS_IPV4_RST = 16'd536;
	localparam logic [15:0] MIN_MSS_IPV6_RST = 16'd1220;

	localparam logic [3:0]  IP_VER4        = 4'd4;
	localparam logic [3:0]  IP_VER6        = 4'd6;
	localparam logic [3:0]  IPV4_MIN_IHL   = 4'd5;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [15:0] OVERHEAD_IPV4  = 16'd40;
	localparam logic [15:0] OVERHEAD_IPV6  = 16'd60;

	localparam logic [6:0]  IPV4_PROTO_POS = 7'd9;
	localparam logic [6:0]  IPV6_NXT_POS   = 7'd6;
	localparam logic [6:0]  IPV6_HDR_LEN   = 7'd40;
	localparam logic [6:0]  TCP_DOFF_POS   = 7'd12;
	localparam logic [6:0]  TCP_FLAGS_POS  = 7'd13;
	localparam logic [6:0]  TCP_CKSUM_POS  = 7'd16;
	localparam logic [6:0]  TCP_HDR_MIN    = 7'd20;

	localparam logic [7:0]  OPT_END        = 8'd0;
	localparam logic [7:0]  OPT_NOP        = 8'd1;
	localparam logic [7:0]  OPT_MSS        = 8'd2;
	localparam logic [7:0]  OPT_LEN_MIN    = 8'd2;
	localparam logic [7:0]  OPT_MSS_LEN    = 8'd4;

	typedef struct packed {
		logic        clamp_needed;
		logic [6:0]  mss_offset;
		logic [15:0] original_mss;
		logic [15:0] new_mss;
		logic [6:0]  checksum_offset;
		logic [15:0] packet_length;
	} result_t;

endpackage

@@ src/tmc_cfg_regs.sv @@
// ============================================================================
// TCP MSS clamp configuration registers
// Holds the per-version MSS floors written through the configuration channel.
// ============================================================================
module tmc_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tmc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [15:0]                       cfg_data,
	output logic [15:0]                       min_mss_ipv4,
	output logic [15:0]                       min_mss_ipv6
);

	logic [15:0] min_mss_ipv4_q;
	logic [15:0] min_mss_ipv6_q;

	assign cfg_ready    = 1'b1;
	assign min_mss_ipv4 = min_mss_ipv4_q;
	assign min_mss_ipv6 = min_mss_ipv6_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mss_ipv4_q <= tmc_pkg::MIN_MSS_IPV4_RST;
			min_mss_ipv6_q <= tmc_pkg::MIN_MSS_IPV6_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tmc_pkg::REG_MIN_MSS_IPV4: min_mss_ipv4_q <= cfg_data;
				tmc_pkg::REG_MIN_MSS_IPV6: min_mss_ipv6_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ src/tmc_parse.sv @@
// ============================================================================
// TCP MSS clamp header parser
// Per-byte IP/TCP header and option walk; forms the edit on the last byte.
// ============================================================================
module tmc_parse #(
	parameter int COUNT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	input  logic [15:0]          path_mtu,
	input  logic [15:0]          min_mss_ipv4,
	input  logic [15:0]          min_mss_ipv6,
	output tmc_pkg::result_t     result
);

	typedef enum logic [1:0] {
		HK_UNKNOWN = 2'd0,
		HK_IPV4    = 2'd1,
		HK_IPV6    = 2'd2,
		HK_OTHER   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_KIND      = 3'd0,
		PH_LEN_OTHER = 3'd1,
		PH_LEN_MSS   = 3'd2,
		PH_MSS_HI    = 3'd3,
		PH_SKIP      = 3'd4,
		PH_DONE      = 3'd5,
		PH_MSS_LO    = 3'd6
	} phase_t;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] pos_q, pos_n;
	kind_t                 kind_q, kind_n;
	logic [6:0]            start_q, start_n;
	logic [6:0]            opt_end_q, opt_end_n;
	logic                  syn_q, syn_n;
	phase_t                phase_q, phase_n;
	logic [7:0]            skip_q, skip_n;
	logic                  mss_found_q, mss_found_n;
	logic [15:0]           found_mss_q, found_mss_n;
	logic [6:0]            found_off_q, found_off_n;
	logic [15:0]           allowed_q, allowed_n;

	logic [COUNT_BITS-1:0] start_ext;
	logic [6:0]            pos7;
	logic [15:0]           mtu_v4;
	logic [15:0]           mtu_v6;
	logic [7:0]            kind_reach;
	logic [8:0]            len_reach;
	logic                  edit_ok;

	always_comb begin
		start_ext   = COUNT_BITS'(start_q);
		pos7        = pos_q[6:0];
		mtu_v4      = path_mtu - tmc_pkg::OVERHEAD_IPV4;
		mtu_v6      = path_mtu - tmc_pkg::OVERHEAD_IPV6;
		kind_reach  = {1'b0, pos7} + 8'd1;
		len_reach   = {2'b00, pos7} - 9'd1 + {1'b0, data_byte};

		pos_n       = (pos_q != CNT_MAX) ? pos_q + 1'b1 : pos_q;
		kind_n      = kind_q;
		start_n     = start_q;
		opt_end_n   = opt_end_q;
		syn_n       = syn_q;
		phase_n     = phase_q;
		skip_n      = skip_q;
		mss_found_n = mss_found_q;
		found_mss_n = found_mss_q;
		found_off_n = found_off_q;
		allowed_n   = allowed_q;

		if (pos_q == '0) begin
			if (data_byte[7:4] == tmc_pkg::IP_VER4 && data_byte[3:0] >= tmc_pkg::IPV4_MIN_IHL) begin
				kind_n    = HK_IPV4;
				start_n   = {1'b0, data_byte[3:0], 2'b00};
				allowed_n = (mtu_v4 < min_mss_ipv4) ? min_mss_ipv4 : mtu_v4;
			end else if (data_byte[7:4] == tmc_pkg::IP_VER6) begin
				kind_n    = HK_IPV6;
				start_n   = tmc_pkg::IPV6_HDR_LEN;
				allowed_n = (mtu_v6 < min_mss_ipv6) ? min_mss_ipv6 : mtu_v6;
			end else begin
				kind_n = HK_OTHER;
			end
		end else if (kind_q == HK_IPV4 || kind_q == HK_IPV6) begin
			if ((kind_q == HK_IPV4 && pos_q == COUNT_BITS'(tmc_pkg::IPV4_PROTO_POS)) ||
			    (kind_q == HK_IPV6 && pos_q == COUNT_BITS'(tmc_pkg::IPV6_NXT_POS))) begin
				if (data_byte != tmc_pkg::PROTO_TCP) begin
					kind_n = HK_OTHER;
				end
			end else if (pos_q == start_ext + COUNT_BITS'(tmc_pkg::TCP_DOFF_POS)) begin
				opt_end_n = start_q + {1'b0, data_byte[7:4], 2'b00};
			end else if (pos_q == start_ext + COUNT_BITS'(tmc_pkg::TCP_FLAGS_POS)) begin
				syn_n = data_byte[1];
			end else if (syn_q && pos_q >= start_ext + COUNT_BITS'(tmc_pkg::TCP_HDR_MIN) &&
			             pos_q < COUNT_BITS'(opt_end_q)) begin
				unique case (phase_q)
					PH_KIND: begin
						if (data_byte == tmc_pkg::OPT_END) begin
							phase_n = PH_DONE;
						end else if (data_byte == tmc_pkg::OPT_NOP) begin
							phase_n = PH_KIND;
						end else if (kind_reach >= {1'b0, opt_end_q}) begin
							phase_n = PH_DONE;
						end else if (data_byte == tmc_pkg::OPT_MSS) begin
							phase_n = PH_LEN_MSS;
						end else begin
							phase_n = PH_LEN_OTHER;
						end
					end
					PH_LEN_OTHER, PH_LEN_MSS: begin
						if (data_byte < tmc_pkg::OPT_LEN_MIN || len_reach > {2'b00, opt_end_q}) begin
							phase_n = PH_DONE;
						end else if (phase_q == PH_LEN_MSS && data_byte == tmc_pkg::OPT_MSS_LEN) begin
							found_off_n = pos7 + 7'd1;
							phase_n     = PH_MSS_HI;
						end else if (data_byte == tmc_pkg::OPT_LEN_MIN) begin
							phase_n = PH_KIND;
						end else begin
							skip_n  = data_byte - tmc_pkg::OPT_LEN_MIN;
							phase_n = PH_SKIP;
						end
					end
					PH_MSS_HI: begin
						found_mss_n = {data_byte, 8'h00};
						phase_n     = PH_MSS_LO;
					end
					PH_MSS_LO: begin
						found_mss_n = {found_mss_q[15:8], data_byte};
						mss_found_n = 1'b1;
						phase_n     = PH_DONE;
					end
					PH_SKIP: begin
						skip_n = skip_q - 8'd1;
						if (skip_n == 8'd0) begin
							phase_n = PH_KIND;
						end
					end
					default: ;
				endcase
			end
		end

		edit_ok = (kind_n == HK_IPV4 || kind_n == HK_IPV6) && syn_n && mss_found_n &&
		          pos_n >= COUNT_BITS'(start_n) + COUNT_BITS'(tmc_pkg::TCP_HDR_MIN) &&
		          pos_n >= COUNT_BITS'(opt_end_n);

		result.clamp_needed    = edit_ok && (found_mss_n > allowed_n);
		result.mss_offset      = edit_ok ? found_off_n : 7'd0;
		result.original_mss    = edit_ok ? found_mss_n : 16'd0;
		result.new_mss         = edit_ok ? allowed_n : 16'd0;
		result.checksum_offset = edit_ok ? start_n + tmc_pkg::TCP_CKSUM_POS : 7'd0;
		result.packet_length   = 16'(pos_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			kind_q      <= HK_UNKNOWN;
			start_q     <= '0;
			opt_end_q   <= '0;
			syn_q       <= 1'b0;
			phase_q     <= PH_KIND;
			skip_q      <= '0;
			mss_found_q <= 1'b0;
			found_mss_q <= '0;
			found_off_q <= '0;
			allowed_q   <= '0;
		end else if (en) begin
			if (last_byte) begin
				pos_q       <= '0;
				kind_q      <= HK_UNKNOWN;
				start_q     <= '0;
				opt_end_q   <= '0;
				syn_q       <= 1'b0;
				phase_q     <= PH_KIND;
				skip_q      <= '0;
				mss_found_q <= 1'b0;
				found_mss_q <= '0;
				found_off_q <= '0;
				allowed_q   <= '0;
			end else begin
				pos_q       <= pos_n;
				kind_q      <= kind_n;
				start_q     <= start_n;
				opt_end_q   <= opt_end_n;
				syn_q       <= syn_n;
				phase_q     <= phase_n;
				skip_q      <= skip_n;
				mss_found_q <= mss_found_n;
				found_mss_q <= found_mss_n;
				found_off_q <= found_off_n;
				allowed_q   <= allowed_n;
			end
		end
	end

endmodule

@@ src/tcp_mss_clamp_parser_unit.sv @@
// ============================================================================
// TCP MSS clamp parser unit
// Streams packet bytes, finds the MSS option of TCP SYN segments, and emits
// one clamp edit per packet.
// ============================================================================
// The slave stream carries one packet byte per transfer, with the path MTU
// beside it and tlast on the final byte; the MTU is used from the first byte.
// The master stream carries one edit per packet, presented after its last
// byte; tuser is set when the MSS has to be rewritten.
// The configuration channel writes the IPv4 and IPv6 MSS floors; it is always
// ready and should be used between packets.
// Each byte is taken into an input register and parsed from there; one byte
// is accepted every cycle while no last byte waits on the output register.
// The edit passes from the input register's last byte into the output register.
// The edit sits in an output register. While it waits, bytes of the next
// packet keep flowing; only the next last byte waits until the edit leaves.
// Reset clears the parse state and empties both registers; the MSS floors
// return to 536 for IPv4 and 1220 for IPv6.
// ============================================================================
module tcp_mss_clamp_parser_unit #(
	parameter int COUNT_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [7:0] data_byte, [23:8] path_mtu
	input  logic [23:0]                     s_axis_tdata,
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [6:0] mss_offset, [22:7] original_mss, [38:23] new_mss,
	// [45:39] checksum_offset, [61:46] packet_length, [63:62] zero
	output logic [63:0]                     m_axis_tdata,
	// [0] clamp_needed
	output logic                            m_axis_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tmc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [15:0]                     cfg_data
);

	logic             s1_valid_q;
	logic [7:0]       s1_byte_s1;
	logic             s1_last_s1;
	logic [15:0]      s1_mtu_s1;
	logic             adv;
	logic             out_free;
	logic             out_valid_q;
	tmc_pkg::result_t res;
	tmc_pkg::result_t out_q;
	logic [15:0]      min_mss_ipv4;
	logic [15:0]      min_mss_ipv6;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign adv           = s1_valid_q && (!s1_last_s1 || out_free);
	assign s_axis_tready = !s1_valid_q || adv;

	tmc_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.min_mss_ipv4 (min_mss_ipv4),
		.min_mss_ipv6 (min_mss_ipv6)
	);

	tmc_parse #(
		.COUNT_BITS (COUNT_BITS)
	) u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (adv),
		.data_byte    (s1_byte_s1),
		.last_byte    (s1_last_s1),
		.path_mtu     (s1_mtu_s1),
		.min_mss_ipv4 (min_mss_ipv4),
		.min_mss_ipv6 (min_mss_ipv6),
		.result       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			s1_byte_s1 <= s_axis_tdata[7:0];
			s1_last_s1 <= s_axis_tlast;
			s1_mtu_s1  <= s_axis_tdata[23:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && s1_last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_last_s1) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.clamp_needed;
	assign m_axis_tdata  = {2'b00, out_q.packet_length, out_q.checksum_offset,
	                        out_q.new_mss, out_q.original_mss, out_q.mss_offset};

`ifndef SYNTHESIS
	a_last_waits: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && s1_last_s1 && out_valid_q && !m_axis_tready |-> !s_axis_tready)
		else $error("last byte advanced while the edit register was held");

	a_edit_source: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q ##1 out_valid_q |-> $past(adv && s1_last_s1))
		else $error("edit appeared without a last byte being parsed");

	a_clamp_smaller: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.clamp_needed |-> out_q.original_mss > out_q.new_mss)
		else $error("clamp flagged without the MSS exceeding the limit");

	a_length_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.packet_length != 16'd0)
		else $error("edit reports an empty packet");
`endif

endmodule

@@ sim/tb_tcp_mss_clamp_parser_unit.sv @@
// ============================================================================
// TCP MSS clamp parser unit testbench
// Builds IPv4 and IPv6 packets around TCP headers with varied option lists,
// streams them byte by byte with random gaps and output stalls, and checks
// every edit against a cycle-free parser kept in step with the accepted
// bytes, or against the given edit of a typed row. A short table of directed
// packets comes first, then random packets under several MSS floor settings.
// ============================================================================
module tb_tcp_mss_clamp_parser_unit;
	import tmc_pkg::*;

	localparam int COUNT_BITS = 16;
	localparam int unsigned COUNT_MAX = (1 << COUNT_BITS) - 1;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic [7:0] TCP_FLAG_SYN = 8'h02;
	localparam logic [7:0] TCP_FLAG_ACK = 8'h10;

	typedef enum logic [1:0] {IPK_UNKNOWN, IPK_V4, IPK_V6, IPK_OTHER} ip_kind_e;
	typedef enum logic [2:0] {
		WK_KIND, WK_LEN_OTHER, WK_LEN_MSS, WK_MSS_HI, WK_SKIP, WK_DONE, WK_MSS_LO
	} walk_e;
	typedef enum int {
		OPTS_MSS, OPTS_NOP_MSS, OPTS_SKIP_MSS, OPTS_END_FIRST, OPTS_SHORT_LEN,
		OPTS_LONG_LEN, OPTS_KIND_LAST, OPTS_WIDE_MSS, OPTS_EMPTY_OPT, OPTS_RANDOM
	} opt_pat_e;

	typedef struct {
		logic [7:0]  ver_ihl;
		logic [7:0]  proto;
		logic [3:0]  doff;
		logic [7:0]  flags;
		opt_pat_e    pat;
		logic [15:0] mss;
		logic [15:0] mtu;
		int          len;
		bit          typed;
		result_t     edit;
	} packet_row_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [23:0]            s_axis_tdata = '0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [63:0]            m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [15:0]            cfg_data = '0;

	result_t     pending_edits[$];
	logic [7:0]  pkt[$];
	packet_row_t dir_rows[25];
	bit          steady = 1'b0;
	int          fail_count = 0;
	int          edit_count = 0;
	int          idle_cycles = 0;

	int unsigned pos;
	ip_kind_e    ip_kind;
	int unsigned tcp_at;
	int unsigned opt_end;
	bit          syn_set;
	walk_e       walk;
	logic [7:0]  skip_left;
	bit          mss_hit;
	logic [15:0] mss_val;
	logic [6:0]  mss_at;
	logic [15:0] mss_cap;
	logic [15:0] floor_v4;
	logic [15:0] floor_v6;

	tcp_mss_clamp_parser_unit #(.COUNT_BITS(COUNT_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void clear_parse();
		pos = 0;
		ip_kind = IPK_UNKNOWN;
		tcp_at = 0;
		opt_end = 0;
		syn_set = 1'b0;
		walk = WK_KIND;
		skip_left = '0;
		mss_hit = 1'b0;
		mss_val = '0;
		mss_at = '0;
		mss_cap = '0;
	endfunction

	function automatic void track_byte(input logic [7:0] b, input bit last,
		input logic [15:0] mtu, output bit has_edit, output result_t edit);
		bit ok;
		logic [15:0] cap;
		has_edit = 1'b0;
		edit = '0;
		if (pos == 0) begin
			if (b[7:4] == IP_VER4 && b[3:0] >= IPV4_MIN_IHL) begin
				ip_kind = IPK_V4;
				tcp_at = b[3:0] * 4;
				cap = mtu - OVERHEAD_IPV4;
				mss_cap = (cap < floor_v4) ? floor_v4 : cap;
			end else if (b[7:4] == IP_VER6) begin
				ip_kind = IPK_V6;
				tcp_at = IPV6_HDR_LEN;
				cap = mtu - OVERHEAD_IPV6;
				mss_cap = (cap < floor_v6) ? floor_v6 : cap;
			end else begin
				ip_kind = IPK_OTHER;
			end
		end else if (ip_kind == IPK_V4 || ip_kind == IPK_V6) begin
			if ((ip_kind == IPK_V4 && pos == IPV4_PROTO_POS) ||
				(ip_kind == IPK_V6 && pos == IPV6_NXT_POS)) begin
				if (b != PROTO_TCP)
					ip_kind = IPK_OTHER;
			end else if (pos == tcp_at + TCP_DOFF_POS) begin
				opt_end = tcp_at + b[7:4] * 4;
			end else if (pos == tcp_at + TCP_FLAGS_POS) begin
				syn_set = b[1];
			end else if (syn_set && pos >= tcp_at + TCP_HDR_MIN && pos < opt_end) begin
				case (walk)
					WK_KIND: begin
						if (b == OPT_END)
							walk = WK_DONE;
						else if (b == OPT_NOP)
							walk = WK_KIND;
						else if (pos + 1 >= opt_end)
							walk = WK_DONE;
						else
							walk = (b == OPT_MSS) ? WK_LEN_MSS : WK_LEN_OTHER;
					end
					WK_LEN_OTHER, WK_LEN_MSS: begin
						if (b < OPT_LEN_MIN || pos - 1 + b > opt_end) begin
							walk = WK_DONE;
						end else if (walk == WK_LEN_MSS && b == OPT_MSS_LEN) begin
							mss_at = 7'(pos + 1);
							walk = WK_MSS_HI;
						end else if (b == OPT_LEN_MIN) begin
							walk = WK_KIND;
						end else begin
							skip_left = b - OPT_LEN_MIN;
							walk = WK_SKIP;
						end
					end
					WK_MSS_HI: begin
						mss_val = {b, 8'h00};
						walk = WK_MSS_LO;
					end
					WK_MSS_LO: begin
						mss_val[7:0] = b;
						mss_hit = 1'b1;
						walk = WK_DONE;
					end
					WK_SKIP: begin
						skip_left = skip_left - 8'd1;
						if (skip_left == 0)
							walk = WK_KIND;
					end
					default: ;
				endcase
			end
		end
		if (pos < COUNT_MAX)
			pos++;
		if (last) begin
			ok = (ip_kind == IPK_V4 || ip_kind == IPK_V6) && syn_set && mss_hit &&
				pos >= tcp_at + TCP_HDR_MIN && pos >= opt_end;
			has_edit = 1'b1;
			edit.clamp_needed = ok && (mss_val > mss_cap);
			if (ok) begin
				edit.mss_offset = mss_at;
				edit.original_mss = mss_val;
				edit.new_mss = mss_cap;
				edit.checksum_offset = 7'(tcp_at + TCP_CKSUM_POS);
			end
			edit.packet_length = 16'(pos);
			clear_parse();
		end
	endfunction

	// A len above zero gives the packet size; otherwise the header is padded
	// with -len payload bytes. The options area is filled from the pattern.
	task automatic build_packet(input logic [7:0] ver_ihl, input logic [7:0] proto,
		input logic [3:0] doff, input logic [7:0] flags, input opt_pat_e pat,
		input logic [15:0] mss, input int len);
		int ip_len, tcp_len, area, full, n, i, seq_n;
		logic [79:0] seq;
		ip_len = (ver_ihl[7:4] == IP_VER6) ? int'(IPV6_HDR_LEN) :
			((ver_ihl[3:0] >= IPV4_MIN_IHL) ? ver_ihl[3:0] * 4 : 20);
		tcp_len = (doff > 5) ? doff * 4 : 20;
		area = tcp_len - 20;
		full = ip_len + tcp_len;
		n = (len > 0) ? len : full - len;
		pkt.delete();
		for (i = 0; i < ((n > full) ? n : full); i++)
			pkt.push_back(8'($urandom));
		pkt[0] = ver_ihl;
		pkt[(ver_ihl[7:4] == IP_VER6) ? IPV6_NXT_POS : IPV4_PROTO_POS] = proto;
		pkt[ip_len + TCP_DOFF_POS] = {doff, 4'($urandom)};
		pkt[ip_len + TCP_FLAGS_POS] = flags;
		seq = '0;
		seq_n = 0;
		case (pat)
			OPTS_MSS: begin
				seq = {OPT_MSS, OPT_MSS_LEN, mss};
				seq_n = 4;
			end
			OPTS_NOP_MSS: begin
				seq = {OPT_NOP, OPT_NOP, OPT_MSS, OPT_MSS_LEN, mss};
				seq_n = 6;
			end
			OPTS_SKIP_MSS: begin
				seq = {8'd3, 8'd3, 8'd7, OPT_MSS, OPT_MSS_LEN, mss};
				seq_n = 7;
			end
			OPTS_END_FIRST: begin
				seq = {OPT_END, OPT_MSS, OPT_MSS_LEN, mss};
				seq_n = 5;
			end
			OPTS_SHORT_LEN: begin
				seq = {8'd8, 8'd1, OPT_MSS, OPT_MSS_LEN, mss};
				seq_n = 6;
			end
			OPTS_LONG_LEN: begin
				seq = {8'd8, 8'hFF, OPT_MSS, OPT_MSS_LEN, mss};
				seq_n = 6;
			end
			OPTS_WIDE_MSS: begin
				seq = {OPT_MSS, 8'd6, mss, 16'd0, OPT_MSS, OPT_MSS_LEN, mss};
				seq_n = 10;
			end
			OPTS_EMPTY_OPT: begin
				seq = {8'd5, OPT_LEN_MIN, OPT_MSS, OPT_MSS_LEN, mss};
				seq_n = 6;
			end
			default: ;
		endcase
		for (i = 0; i < seq_n && i < area; i++)
			pkt[ip_len + 20 + i] = seq[8 * (seq_n - 1 - i) +: 8];
		if (pat == OPTS_KIND_LAST && area > 0) begin
			for (i = 0; i < area - 1; i++)
				pkt[ip_len + 20 + i] = OPT_NOP;
			pkt[ip_len + 20 + area - 1] = OPT_MSS;
		end
		if (pat == OPTS_RANDOM) begin
			for (i = 0; i < area; i++)
				pkt[ip_len + 20 + i] = $urandom_range(1) ? 8'($urandom_range(5)) : 8'($urandom);
		end
		while (pkt.size() > n)
			void'(pkt.pop_back());
	endtask

	task automatic make_random_packet(output logic [15:0] mtu);
		int kind, n, i;
		logic [7:0] vi, proto, flags;
		logic [3:0] doff;
		logic [15:0] mss, near;
		opt_pat_e pat;
		bit cut;
		kind = $urandom_range(99);
		mtu = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(576, 9000));
		if (kind < 10) begin
			pkt.delete();
			n = $urandom_range(1, 64);
			for (i = 0; i < n; i++)
				pkt.push_back(8'($urandom));
			return;
		end
		vi = ($urandom_range(2) == 0) ? {IP_VER6, 4'($urandom)} :
			{IP_VER4, ($urandom_range(3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5};
		proto = PROTO_TCP;
		doff = 4'($urandom_range(6, ($urandom_range(3) == 0) ? 15 : 8));
		flags = 8'($urandom) | TCP_FLAG_SYN;
		pat = $urandom_range(1) ? ($urandom_range(1) ? OPTS_MSS : OPTS_NOP_MSS) :
			opt_pat_e'($urandom_range(9));
		near = mtu - ((vi[7:4] == IP_VER6) ? OVERHEAD_IPV6 : OVERHEAD_IPV4);
		mss = $urandom_range(1) ? near + 16'($urandom_range(4)) - 16'd2 : 16'($urandom);
		cut = 1'b0;
		if (kind >= 75) begin
			case ($urandom_range(4))
				0: vi = 8'($urandom);
				1: proto = $urandom_range(1) ? 8'($urandom) : 8'd17;
				2: flags = 8'($urandom);
				3: begin
					doff = 4'($urandom);
					pat = OPTS_RANDOM;
				end
				default: cut = 1'b1;
			endcase
		end
		build_packet(vi, proto, doff, flags, pat, mss,
			($urandom_range(3) == 0) ? -$urandom_range(1, 12) : 0);
		if (cut) begin
			n = $urandom_range(1, pkt.size());
			while (pkt.size() > n)
				void'(pkt.pop_back());
		end
	endtask

	task automatic send_packet(input logic [15:0] mtu, input bit typed, input result_t want);
		int i;
		bit last, has_edit;
		logic [15:0] byte_mtu;
		result_t edit;
		for (i = 0; i < pkt.size(); i++) begin
			if (!steady) begin
				while ($urandom_range(99) < 16) begin
					s_axis_tvalid <= 1'b0;
					@(posedge clk);
				end
			end
			last = (i == pkt.size() - 1);
			byte_mtu = (i == 0) ? mtu : 16'($urandom);
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= {byte_mtu, pkt[i]};
			s_axis_tlast <= last;
			@(posedge clk);
			while (!s_axis_tready)
				@(posedge clk);
			track_byte(pkt[i], last, byte_mtu, has_edit, edit);
			if (has_edit)
				pending_edits.push_back(typed ? want : edit);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_edits.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_floors(input logic [15:0] v4, input logic [15:0] v6);
		cfg_valid <= 1'b1;
		cfg_index <= REG_MIN_MSS_IPV4;
		cfg_data <= v4;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		floor_v4 = v4;
		cfg_index <= REG_MIN_MSS_IPV6;
		cfg_data <= v6;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		floor_v6 = v6;
		cfg_valid <= 1'b0;
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		fail_count++;
		if (fail_count <= 40)
			$display("edit %0d: %s is 0x%0h, expected 0x%0h", edit_count, what, got, want);
	endtask

	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= 16);
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_edits.size() == 0) begin
				report_mismatch("edit with none pending", 1, 0);
			end else begin
				want = pending_edits.pop_front();
				if (m_axis_tuser !== want.clamp_needed)
					report_mismatch("clamp_needed", m_axis_tuser, want.clamp_needed);
				if (m_axis_tdata[6:0] !== want.mss_offset)
					report_mismatch("mss_offset", m_axis_tdata[6:0], want.mss_offset);
				if (m_axis_tdata[22:7] !== want.original_mss)
					report_mismatch("original_mss", m_axis_tdata[22:7], want.original_mss);
				if (m_axis_tdata[38:23] !== want.new_mss)
					report_mismatch("new_mss", m_axis_tdata[38:23], want.new_mss);
				if (m_axis_tdata[45:39] !== want.checksum_offset)
					report_mismatch("checksum_offset", m_axis_tdata[45:39],
						want.checksum_offset);
				if (m_axis_tdata[61:46] !== want.packet_length)
					report_mismatch("packet_length", m_axis_tdata[61:46], want.packet_length);
			end
			edit_count++;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tcp_mss_clamp_parser_unit verification failed");
			$finish;
		end
	end

	initial begin
		int r, phase, bytes, pkts;
		logic [15:0] mtu;
		clear_parse();
		floor_v4 = MIN_MSS_IPV4_RST;
		floor_v6 = MIN_MSS_IPV6_RST;
		dir_rows = '{
			'{8'h45, PROTO_TCP, 4'd6, TCP_FLAG_SYN, OPTS_MSS, 16'd1460, 16'd1500, 1,
				1'b1, '{1'b0, 7'd0, 16'd0, 16'd0, 7'd0, 16'd1}},
			'{8'h55, PROTO_TCP, 4'd6, TCP_FLAG_SYN, OPTS_MSS, 16'd1460, 16'd1500, 44,
				1'b1, '{1'b0, 7'd0, 16'd0, 16'd0, 7'd0, 16'd44}},
			'{8'h44, PROTO_TCP, 4'd6, TCP_FLAG_SYN, OPTS_MSS, 16'd1460, 16'd1500, 44,
				1'b1, '{1'b0, 7'd0, 16'd0, 16'd0, 7'd0, 16'd44}},
			'{8'h45, 8'd17, 4'd6, TCP_FLAG_SYN, OPTS_MSS, 16'd1460, 16'd1500, 44,
				1'b1, '{1'b0, 7'd0, 16'd0, 16'd0, 7'd0, 16'd44}},
			'{8'h45, PROTO_TCP, 4'd6, TCP_FLAG_ACK, OPTS_MSS, 16'd1460, 16'd1500, 44,
				1'b1, '{1'b0, 7'd0, 16'd0, 16'd0, 7'd0, 16'd44}},
			'{8'h45, PROTO_TCP, 4'd5, TCP_FLAG_SYN, OPTS_MSS, 16'd1460, 16'd1500, 40,
				1'b1, '{1'b0, 7'd0, 16'd0, 16'd0, 7'd0, 16'd40}},
			'{8'h45, PROTO_TCP, 4'd6, TCP_FLAG_SYN, OPTS_MSS, 16'd1460, 16'd1500, 43,
				1'b1, '{1'b0, 7'd0, 16'd0, 16'd0, 7'd0, 16'd43}},
			'{8'h45, PROTO_TCP, 4'd6, TCP_FLAG_SYN, OPTS_MSS, 16'd1460, 16'd1500, 44,
				1'b1, '{1'b0, 7'd42, 16'd1460, 16'd1460, 7'd36, 16'd44}},
			'{8'h45, PROTO_TCP, 4'd6, TCP_FLAG_SYN, OPTS_MSS, 16'd1460, 16'd1400, 44,
				1'b1, '{1'b1, 7'd42, 16'd1460, 16'd1360, 7'd36, 16'd44}},
			'{8'h60, PROTO_TCP, 4'd6, TCP_FLAG_SYN, OPTS_MSS, 16'd1460, 16'd1500, 84,
				1'b1, '{1'b1, 7'd62, 16'd1460, 16'd1440, 7'd56, 16'd84}},
			'{8'h60, PROTO_TCP, 4'd6, TCP_FLAG_SYN, OPTS_MSS, 16'd1220, 16'd1280, 0,
				1'b0, '0},
			'{8'h45, PROTO_TCP, 4'd6, TCP_FLAG_SYN, OPTS_MSS, 16'hFFFF, 16'd0, 0,
				1'b0, '0},
			'{8'h45, PROTO_TCP, 4'd6, 8'hFF, OPTS_MSS, 16'd600, 16'd100, 0,
				1'b0, '0},
			'{8'h45, PROTO_TCP, 4'd7, TCP_FLAG_SYN, OPTS_NOP_MSS, 16'd9000, 16'd1500, 0,
				1'b0, '0},
			'{8'h46, PROTO_TCP, 4'd8, TCP_FLAG_SYN, OPTS_SKIP_MSS, 16'd1460, 16'd1200, 0,
				1'b0, '0},
			'{8'h45, PROTO_TCP, 4'd7, TCP_FLAG_SYN, OPTS_END_FIRST, 16'd9000, 16'd1500, 0,
				1'b0, '0},
			'{8'h45, PROTO_TCP, 4'd7, TCP_FLAG_SYN, OPTS_SHORT_LEN, 16'd9000, 16'd1500, 0,
				1'b0, '0},
			'{8'h45, PROTO_TCP, 4'd7, TCP_FLAG_SYN, OPTS_LONG_LEN, 16'd9000, 16'd1500, 0,
				1'b0, '0},
			'{8'h45, PROTO_TCP, 4'd6, TCP_FLAG_SYN, OPTS_KIND_LAST, 16'd9000, 16'd1500, 0,
				1'b0, '0},
			'{8'h65, PROTO_TCP, 4'd8, TCP_FLAG_SYN, OPTS_WIDE_MSS, 16'd9000, 16'd1500, 0,
				1'b0, '0},
			'{8'h45, PROTO_TCP, 4'd7, TCP_FLAG_SYN, OPTS_EMPTY_OPT, 16'd9000, 16'd1500, 0,
				1'b0, '0},
			'{8'h4F, PROTO_TCP, 4'd15, 8'hFF, OPTS_MSS, 16'hFFFF, 16'hFFFF, 0,
				1'b0, '0},
			'{8'h6F, PROTO_TCP, 4'd15, TCP_FLAG_SYN, OPTS_RANDOM, 16'd0, 16'd9000, -5,
				1'b0, '0},
			'{8'hFF, 8'hFF, 4'd15, 8'hFF, OPTS_RANDOM, 16'hFFFF, 16'hFFFF, 44,
				1'b1, '{1'b0, 7'd0, 16'd0, 16'd0, 7'd0, 16'd44}},
			'{8'h45, PROTO_TCP, 4'd6, TCP_FLAG_SYN, OPTS_MSS, 16'd1460, 16'd1400, 70000,
				1'b0, '0}
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (r = 0; r < $size(dir_rows); r++) begin
			build_packet(dir_rows[r].ver_ihl, dir_rows[r].proto, dir_rows[r].doff,
				dir_rows[r].flags, dir_rows[r].pat, dir_rows[r].mss, dir_rows[r].len);
			send_packet(dir_rows[r].mtu, dir_rows[r].typed, dir_rows[r].edit);
		end
		for (phase = 0; phase < 4; phase++) begin
			drain();
			case (phase)
				0: set_floors(16'd0, 16'd0);
				1: set_floors(16'hFFFF, 16'hFFFF);
				2: set_floors(16'($urandom), 16'($urandom));
				default: set_floors(16'($urandom_range(500, 1500)),
					16'($urandom_range(1200, 2000)));
			endcase
			bytes = 0;
			pkts = 0;
			while (bytes < 325 || pkts < 16) begin
				steady = (phase == 2 && pkts >= 4 && pkts < 14);
				if (phase == 3 && pkts == 8)
					drain();
				make_random_packet(mtu);
				send_packet(mtu, 1'b0, '0);
				bytes += pkt.size();
				pkts++;
			end
		end
		steady = 1'b0;
		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending_edits.size() == 0)
			$display("tcp_mss_clamp_parser_unit verification clean");
		else
			$display("tcp_mss_clamp_parser_unit verification failed");
		$finish;
	end

endmodule
